/* hw/rtl/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared codes and field widths for the contiguous frame allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int FRAME_W  = 20;
	localparam int LEN_W    = 11;
	localparam int COUNT_W  = 11;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int FST_W    = 2;

	// Per-frame state codes
	localparam logic [FST_W-1:0] FST_FREE  = 2'b11;
	localparam logic [FST_W-1:0] FST_HEAD  = 2'b01;
	localparam logic [FST_W-1:0] FST_ALLOC = 2'b00;

	// Actions
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_MARK    = 2'd2;

	// Result status
	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NO_ROOM  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOT_HEAD = 2'd2;
	localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd3;

endpackage

/* hw/rtl/cfa_ifs.sv */
// ----------------------------------------------------------------------------
// cfa_ifs
// Request and result channels of the contiguous frame allocator.
// ----------------------------------------------------------------------------
interface cfa_in_if;
	logic                         valid;
	logic                         ready;
	logic [cfa_pkg::ACTION_W-1:0] action;
	logic [cfa_pkg::FRAME_W-1:0]  frame_no;
	logic [cfa_pkg::LEN_W-1:0]    run_length;

	modport source (output valid, action, frame_no, run_length, input ready);
	modport sink   (input valid, action, frame_no, run_length, output ready);
endinterface

interface cfa_out_if;
	logic                         valid;
	logic                         ready;
	logic [cfa_pkg::FRAME_W-1:0]  start_frame;
	logic [cfa_pkg::STATUS_W-1:0] status;
	logic [cfa_pkg::COUNT_W-1:0]  free_count;

	modport source (output valid, start_frame, status, free_count, input ready);
	modport sink   (input valid, start_frame, status, free_count, output ready);
endinterface

/* hw/rtl/contiguous_frame_allocator_core.sv */
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_core
// First-fit contiguous frame allocator over a 2-bit-per-frame state memory.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake           Payload
//  in_item   in   valid/ready         action, frame_no, run_length
//  out_item  out  valid/ready         start_frame, status, free_count
//  cfg       in   cfg_wr_en           cfg_wr_data = base_frame
//
//  One item at a time; the frame memory port is walked one frame per cycle.
//  Allocate: a first-fit scan of the frames up to a fit (or to the end of the pool
//  when there is no room), then a marking walk over the run_length frames.
//  Release: a walk over the freed frames; mark: a walk over run_length frames.
//  After reset a clearing pass over all POOL_FRAMES frames runs before in_item.ready.
//  A result waits in the output register; the next item is taken meanwhile
//  and holds its result until the register is free.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_core #(
	parameter int POOL_FRAMES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [cfa_pkg::FRAME_W-1:0] cfg_wr_data,
	cfa_in_if.sink                      in_item,
	cfa_out_if.source                   out_item
);

	localparam int IW = $clog2(POOL_FRAMES);
	localparam int CW = $clog2(POOL_FRAMES + 1);
	localparam int XW = (CW > cfa_pkg::LEN_W) ? CW : cfa_pkg::LEN_W;
	localparam logic [CW-1:0] NFR = CW'(POOL_FRAMES);
	localparam logic [IW-1:0] LAST = IW'(POOL_FRAMES - 1);
	localparam logic [XW-1:0] NFR_X = XW'(POOL_FRAMES);
	localparam logic [cfa_pkg::FRAME_W-1:0] NFR_F = cfa_pkg::FRAME_W'(POOL_FRAMES);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MARK = 3'd4;
	localparam logic [2:0] S_REL  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	// control
	logic [2:0]                          state_q, state_d;
	logic [CW-1:0]                       ptr_q, ptr_d;
	logic [CW-1:0]                       run_q, run_d;
	logic                                first_q, first_d;
	logic [CW-1:0]                       free_q, free_d;
	logic [cfa_pkg::FRAME_W-1:0]         base_q;
	logic                                ov_q, ov_d;
	logic                                rd_vld_s1;

	// payload
	logic [cfa_pkg::ACTION_W-1:0]        act_q;
	logic [cfa_pkg::FRAME_W-1:0]         fno_q;
	logic [cfa_pkg::LEN_W-1:0]           len_q;
	logic [IW-1:0]                       found_q, found_d;
	logic [CW-1:0]                       end_q, end_d;
	logic [cfa_pkg::FRAME_W-1:0]         sfr_q, sfr_d;
	logic [cfa_pkg::STATUS_W-1:0]        sts_q, sts_d;
	logic [cfa_pkg::FRAME_W-1:0]         o_start_q;
	logic [cfa_pkg::STATUS_W-1:0]        o_status_q;
	logic [cfa_pkg::COUNT_W-1:0]         o_free_q;
	logic [IW-1:0]                       rd_addr_s1;

	// memory port
	logic                                wr_en;
	logic [IW-1:0]                       wr_addr;
	logic [cfa_pkg::FST_W-1:0]           wr_data;
	logic                                rd_en;
	logic [IW-1:0]                       rd_addr;
	logic [cfa_pkg::FST_W-1:0]           rd_data;

	logic                                in_acc;
	logic                                out_load;

	cfa_frame_mem #(
		.DEPTH (POOL_FRAMES),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_item.ready = (state_q == S_IDLE);
	assign in_acc        = in_item.valid && in_item.ready;
	assign out_load      = (state_q == S_FIN) && (!ov_q || out_item.ready);

	assign out_item.valid       = ov_q;
	assign out_item.start_frame = o_start_q;
	assign out_item.status      = o_status_q;
	assign out_item.free_count  = o_free_q;

	always_comb begin
		logic [cfa_pkg::FRAME_W-1:0] off;
		logic                        in_rng;
		logic [XW-1:0]               len_x;
		logic [CW-1:0]               run_n;
		logic [IW-1:0]               fstart;
		logic                        issue;

		off    = fno_q - base_q;
		in_rng = (fno_q >= base_q) && (off < NFR_F);
		len_x  = XW'(len_q);
		run_n  = run_q + CW'(1);
		fstart = (run_q == '0) ? rd_addr_s1 : found_q;
		issue  = 1'b0;

		state_d = state_q;
		ptr_d   = ptr_q;
		run_d   = run_q;
		first_d = first_q;
		free_d  = free_q;
		found_d = found_q;
		end_d   = end_q;
		sfr_d   = sfr_q;
		sts_d   = sts_q;
		wr_en   = 1'b0;
		wr_addr = rd_addr_s1;
		wr_data = cfa_pkg::FST_FREE;
		rd_en   = 1'b0;
		rd_addr = ptr_q[IW-1:0];
		ov_d    = ov_q;

		if (ov_q && out_item.ready) begin
			ov_d = 1'b0;
		end

		unique case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[IW-1:0];
				ptr_d   = ptr_q + CW'(1);
				if (ptr_q[IW-1:0] == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				sfr_d = '0;
				sts_d = cfa_pkg::STS_OK;
				unique case (act_q)
					cfa_pkg::ACT_ALLOC: begin
						if (len_q == '0) begin
							sts_d   = cfa_pkg::STS_RANGE;
							state_d = S_FIN;
						end else if (len_x > NFR_X) begin
							sts_d   = cfa_pkg::STS_NO_ROOM;
							state_d = S_FIN;
						end else begin
							ptr_d   = '0;
							run_d   = '0;
							state_d = S_SCAN;
						end
					end
					cfa_pkg::ACT_RELEASE: begin
						if (!in_rng) begin
							sts_d   = cfa_pkg::STS_RANGE;
							state_d = S_FIN;
						end else begin
							ptr_d   = CW'(off);
							first_d = 1'b1;
							state_d = S_REL;
						end
					end
					cfa_pkg::ACT_MARK: begin
						if (len_q == '0 || !in_rng || len_x > NFR_X - XW'(off)) begin
							sts_d   = cfa_pkg::STS_RANGE;
							state_d = S_FIN;
						end else begin
							found_d = IW'(off);
							ptr_d   = CW'(off);
							end_d   = CW'(off) + CW'(len_q);
							state_d = S_MARK;
						end
					end
					default: begin
						sts_d   = cfa_pkg::STS_RANGE;
						state_d = S_FIN;
					end
				endcase
			end
			S_SCAN: begin
				issue = (ptr_q < NFR);
				if (rd_vld_s1) begin
					if (rd_data == cfa_pkg::FST_FREE) begin
						found_d = fstart;
						run_d   = run_n;
						if (XW'(run_n) == len_x) begin
							// run found: hand over to the marking walk
							issue   = 1'b0;
							ptr_d   = CW'(fstart);
							end_d   = CW'(fstart) + CW'(len_q);
							state_d = S_MARK;
						end
					end else begin
						run_d = '0;
					end
				end else if (!issue) begin
					sts_d   = cfa_pkg::STS_NO_ROOM;
					state_d = S_FIN;
				end
				if (issue) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + CW'(1);
				end
			end
			S_MARK: begin
				issue = (ptr_q != end_q);
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_data = (rd_addr_s1 == found_q) ? cfa_pkg::FST_HEAD
					                                  : cfa_pkg::FST_ALLOC;
					if (rd_data == cfa_pkg::FST_FREE) begin
						free_d = free_q - CW'(1);
					end
				end else if (!issue) begin
					if (act_q == cfa_pkg::ACT_ALLOC) begin
						sfr_d = base_q + cfa_pkg::FRAME_W'(found_q);
					end
					state_d = S_FIN;
				end
				if (issue) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + CW'(1);
				end
			end
			S_REL: begin
				issue = (ptr_q < NFR);
				if (rd_vld_s1) begin
					if (first_q && rd_data != cfa_pkg::FST_HEAD) begin
						issue   = 1'b0;
						sts_d   = cfa_pkg::STS_NOT_HEAD;
						state_d = S_FIN;
					end else if (first_q || rd_data == cfa_pkg::FST_ALLOC) begin
						first_d = 1'b0;
						wr_en   = 1'b1;
						free_d  = free_q + CW'(1);
					end else begin
						// end of the run
						issue   = 1'b0;
						state_d = S_FIN;
					end
				end else if (!issue) begin
					state_d = S_FIN;
				end
				if (issue) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + CW'(1);
				end
			end
			S_FIN: begin
				if (out_load) begin
					ov_d    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			ptr_q     <= '0;
			run_q     <= '0;
			first_q   <= 1'b0;
			free_q    <= NFR;
			base_q    <= '0;
			ov_q      <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			ptr_q     <= ptr_d;
			run_q     <= run_d;
			first_q   <= first_d;
			free_q    <= free_d;
			ov_q      <= ov_d;
			rd_vld_s1 <= rd_en;
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= in_item.action;
			fno_q <= in_item.frame_no;
			len_q <= in_item.run_length;
		end
		found_q    <= found_d;
		end_q      <= end_d;
		sfr_q      <= sfr_d;
		sts_q      <= sts_d;
		rd_addr_s1 <= rd_addr;
		if (out_load) begin
			o_start_q  <= sfr_q;
			o_status_q <= sts_q;
			o_free_q   <= cfa_pkg::COUNT_W'(free_q);
		end
	end

endmodule

/* hw/rtl/cfa_frame_mem.sv */
// ----------------------------------------------------------------------------
// cfa_frame_mem
// Frame state memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cfa_frame_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [cfa_pkg::FST_W-1:0]    wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic [cfa_pkg::FST_W-1:0]    rd_data
);

	logic [cfa_pkg::FST_W-1:0] mem [DEPTH];
	logic [cfa_pkg::FST_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* test/contiguous_frame_allocator_core_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_core_checker
// Watches the request and result channels of the allocator and keeps its own
// frame map and free count. Each accepted request is served against this map,
// and each accepted result is compared field by field with the oldest reply
// still owed.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_core_checker import cfa_pkg::*; #(
	parameter int POOL_FRAMES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [FRAME_W-1:0] cfg_wr_data,
	cfa_in_if                  in_item,
	cfa_out_if                 out_item,
	output int unsigned        fail_count,
	output int unsigned        results_owed
);

	typedef struct packed {
		logic [FRAME_W-1:0]  start_frame;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  free_count;
	} reply_t;

	logic [FST_W-1:0]   frame_state [POOL_FRAMES];
	int unsigned        frames_free;
	logic [FRAME_W-1:0] pool_base;
	reply_t             owed_replies [$];

	function automatic void reset_pool();
		for (int i = 0; i < POOL_FRAMES; i++)
			frame_state[i] = FST_FREE;
		frames_free = POOL_FRAMES;
		pool_base = '0;
	endfunction

	// Head on the first frame, allocated on the rest; count only frames that were free.
	function automatic void claim_run(input int unsigned at, input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if (frame_state[at + i] == FST_FREE)
				frames_free--;
			frame_state[at + i] = (i == 0) ? FST_HEAD : FST_ALLOC;
		end
	endfunction

	function automatic reply_t serve_request(input logic [ACTION_W-1:0] act,
			input logic [FRAME_W-1:0] fno, input logic [LEN_W-1:0] len);
		reply_t      r;
		int unsigned offset;
		int unsigned run;
		int unsigned run_start;
		int unsigned k;
		bit          fits;
		r.start_frame = '0;
		r.status = STS_OK;
		run = 0;
		run_start = 0;
		fits = 1'b0;
		offset = 32'(fno) - 32'(pool_base);
		case (act)
			ACT_ALLOC: begin
				if (len == 0) begin
					r.status = STS_RANGE;
				end else begin
					for (k = 0; k < POOL_FRAMES && !fits; k++) begin
						if (frame_state[k] == FST_FREE) begin
							if (run == 0)
								run_start = k;
							run++;
							if (run == len)
								fits = 1'b1;
						end else begin
							run = 0;
						end
					end
					if (fits) begin
						claim_run(run_start, len);
						r.start_frame = pool_base + FRAME_W'(run_start);
					end else begin
						r.status = STS_NO_ROOM;
					end
				end
			end
			ACT_RELEASE: begin
				if (fno < pool_base || offset >= POOL_FRAMES) begin
					r.status = STS_RANGE;
				end else if (frame_state[offset] != FST_HEAD) begin
					r.status = STS_NOT_HEAD;
				end else begin
					frame_state[offset] = FST_FREE;
					frames_free++;
					k = offset + 1;
					while (k < POOL_FRAMES && frame_state[k] == FST_ALLOC) begin
						frame_state[k] = FST_FREE;
						frames_free++;
						k++;
					end
				end
			end
			ACT_MARK: begin
				if (len == 0 || fno < pool_base || offset >= POOL_FRAMES ||
						len > POOL_FRAMES - offset)
					r.status = STS_RANGE;
				else
					claim_run(offset, len);
			end
			default: begin
				r.status = STS_RANGE;
			end
		endcase
		r.free_count = COUNT_W'(frames_free);
		return r;
	endfunction

	task automatic check_reply();
		reply_t got;
		reply_t want;
		got.start_frame = out_item.start_frame;
		got.status = out_item.status;
		got.free_count = out_item.free_count;
		if (owed_replies.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("checker: unexpected result start %h status %0d free %0d",
					got.start_frame, got.status, got.free_count);
		end else begin
			want = owed_replies.pop_front();
			if (got.start_frame !== want.start_frame || got.status !== want.status ||
					got.free_count !== want.free_count) begin
				fail_count++;
				if (fail_count <= 10)
					$display({"checker: mismatch, expected start %h status %0d free %0d,",
						" got start %h status %0d free %0d"},
						want.start_frame, want.status, want.free_count,
						got.start_frame, got.status, got.free_count);
			end
		end
	endtask

	initial begin
		reset_pool();
		fail_count = 0;
		results_owed = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_pool();
			owed_replies.delete();
			results_owed = 0;
		end else begin
			// Results leaving now belong to earlier requests, so check before predicting.
			if (out_item.valid && out_item.ready)
				check_reply();
			if (cfg_wr_en)
				pool_base = cfg_wr_data;
			if (in_item.valid && in_item.ready)
				owed_replies.push_back(serve_request(in_item.action, in_item.frame_no,
					in_item.run_length));
			results_owed = owed_replies.size();
		end
	end

endmodule

/* test/contiguous_frame_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_core_tb
// Drives allocate, release and mark requests into the allocator with random
// gaps on both channels and a long result stall, across several pool base
// settings. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_core_tb;
	import cfa_pkg::*;

	localparam int POOL_FRAMES    = 1024;
	localparam int HOLD_CYCLES    = 3000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 100;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [FRAME_W-1:0]  slot;
	} request_note_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en = 1'b0;
	logic [FRAME_W-1:0] cfg_wr_data = '0;
	int unsigned        fail_count;
	int unsigned        results_owed;

	logic [FRAME_W-1:0] cur_base = '0;
	logic [FRAME_W-1:0] live_heads [$];
	request_note_t      requests_in_flight [$];
	int unsigned        items_sent = 0;
	int unsigned        results_taken = 0;
	int unsigned        quiet_cycles = 0;
	bit                 hold_req = 1'b0;
	bit                 hold_done = 1'b0;

	cfa_in_if  in_item ();
	cfa_out_if out_item ();

	contiguous_frame_allocator_core #(
		.POOL_FRAMES(POOL_FRAMES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_item    (in_item),
		.out_item   (out_item)
	);

	contiguous_frame_allocator_core_checker #(
		.POOL_FRAMES(POOL_FRAMES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_item),
		.out_item    (out_item),
		.fail_count  (fail_count),
		.results_owed(results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("contiguous_frame_allocator_core_tb failed");
				$finish;
			end
		end
	end

	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned s;
		s = $urandom_range(0, 99);
		if (s < 70)
			return LEN_W'($urandom_range(1, 16));
		else if (s < 90)
			return LEN_W'($urandom_range(17, 128));
		else if (s < 96)
			return LEN_W'($urandom_range(129, POOL_FRAMES));
		else if (s < 98)
			return '0;
		return LEN_W'($urandom_range(POOL_FRAMES + 1, 2047));
	endfunction

	// Start at a falling edge; return at the falling edge after acceptance.
	task automatic offer(input logic [ACTION_W-1:0] act, input logic [FRAME_W-1:0] fno,
			input logic [LEN_W-1:0] len);
		int unsigned gap;
		request_note_t note;
		gap = ((items_sent / 32) % 4 == 3) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_item.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item.valid <= 1'b1;
		in_item.action <= act;
		in_item.frame_no <= fno;
		in_item.run_length <= len;
		@(posedge clk);
		while (!in_item.ready)
			@(posedge clk);
		note.act = act;
		note.slot = fno - cur_base;
		requests_in_flight.push_back(note);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic offer_random();
		int unsigned pick;
		int unsigned j;
		logic [ACTION_W-1:0] act;
		logic [FRAME_W-1:0] fno;
		logic [LEN_W-1:0] len;
		pick = $urandom_range(0, 99);
		act = ACT_ALLOC;
		fno = FRAME_W'($urandom);
		len = pick_length();
		if (pick < 40) begin
			act = ACT_ALLOC;
		end else if (pick < 65 && live_heads.size() > 0) begin
			act = ACT_RELEASE;
			j = $urandom_range(0, live_heads.size() - 1);
			fno = cur_base + live_heads[j];
			live_heads.delete(j);
		end else if (pick < 75) begin
			act = ACT_RELEASE;
			fno = cur_base + FRAME_W'($urandom_range(0, POOL_FRAMES + 76));
		end else if (pick < 87) begin
			act = ACT_MARK;
			fno = cur_base + FRAME_W'($urandom_range(0, POOL_FRAMES + 6));
			if ($urandom_range(0, 19) != 0)
				len = LEN_W'($urandom_range(1, 12));
		end else if (pick < 92) begin
			act = ACT_UNUSED;
		end else begin
			act = ACTION_W'($urandom_range(0, 3));
			len = LEN_W'($urandom);
		end
		offer(act, fno, len);
	endtask

	// Write the base only once the block has handed back everything.
	task automatic set_base(input logic [FRAME_W-1:0] value);
		in_item.valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		cur_base = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: random stalls, one long hold-off, and record live run heads.
	initial begin
		int unsigned gap;
		request_note_t note;
		out_item.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = ((results_taken / 32) % 4 == 1) ? 0 : $urandom_range(0, 7);
			if (hold_req && !hold_done) begin
				out_item.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (gap > 0) begin
				out_item.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_item.ready <= 1'b1;
			@(posedge clk);
			while (!out_item.valid)
				@(posedge clk);
			if (requests_in_flight.size() > 0) begin
				note = requests_in_flight.pop_front();
				if (out_item.status == STS_OK && note.act == ACT_ALLOC)
					live_heads.push_back(out_item.start_frame - cur_base);
				else if (out_item.status == STS_OK && note.act == ACT_MARK)
					live_heads.push_back(note.slot);
			end
			results_taken++;
			@(negedge clk);
		end
	end

	initial begin
		logic [FRAME_W-1:0] phase_base [5];
		arst_n = 1'b0;
		in_item.valid = 1'b0;
		in_item.action = ACT_ALLOC;
		in_item.frame_no = '0;
		in_item.run_length = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on an empty pool at base zero
		offer(ACT_ALLOC, '0, 11'd0);
		offer(ACT_ALLOC, '0, 11'd1);
		offer(ACT_ALLOC, '0, 11'd1024);
		offer(ACT_ALLOC, '0, 11'd2047);
		offer(ACT_RELEASE, 20'd0, 11'd1);
		offer(ACT_ALLOC, '0, 11'd1024);
		offer(ACT_ALLOC, '0, 11'd1);
		offer(ACT_RELEASE, 20'd5, 11'd1);
		offer(ACT_RELEASE, 20'd1024, 11'd1);
		offer(ACT_RELEASE, 20'hFFFFF, 11'd1);
		offer(ACT_RELEASE, 20'd0, 11'd1);
		offer(ACT_MARK, 20'd1023, 11'd1);
		offer(ACT_MARK, 20'd1020, 11'd5);
		offer(ACT_MARK, 20'd1000, 11'd0);
		offer(ACT_MARK, 20'hFFFFF, 11'd1);
		offer(ACT_MARK, 20'd10, 11'd4);
		offer(ACT_MARK, 20'd12, 11'd4);
		offer(ACT_RELEASE, 20'd10, 11'd1);
		offer(ACT_RELEASE, 20'd1023, 11'd1);
		offer(ACT_UNUSED, 20'hFFFFF, 11'd2047);
		offer(ACT_ALLOC, '0, 11'd3);

		// Top base: start frames wrap past the 20-bit limit
		set_base(20'hFFFFF);
		offer(ACT_ALLOC, '0, 11'd1);
		offer(ACT_RELEASE, 20'hFFFFF, 11'd1);
		offer(ACT_RELEASE, 20'd0, 11'd1);
		offer(ACT_MARK, 20'hFFFFF, 11'd1024);

		phase_base[0] = '0;
		phase_base[1] = 20'hFFF00;
		phase_base[2] = FRAME_W'($urandom);
		phase_base[3] = 20'h80000;
		phase_base[4] = 20'hFFFFF;
		for (int p = 0; p < 5; p++) begin
			set_base(phase_base[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == 40)
					hold_req = 1'b1;
				offer_random();
			end
		end

		in_item.valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("contiguous_frame_allocator_core_tb passed");
		else
			$display("contiguous_frame_allocator_core_tb failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_ifs.sv
hw/rtl/cfa_frame_mem.sv
hw/rtl/contiguous_frame_allocator_core.sv
test/contiguous_frame_allocator_core_checker.sv
test/contiguous_frame_allocator_core_tb.sv
